/* rtl/pcba_pkg.sv */
// ----------------------------------------------------------------------------
// pcba_pkg
// shared types, constants and codes of the paged cache block allocator
// ----------------------------------------------------------------------------
package pcba_pkg;

  localparam int POOL_BLOCKS        = 1024;
  localparam int MAX_SEQS           = 64;
  localparam int MAX_BLOCKS_PER_SEQ = 32;

  localparam int BLK_W  = $clog2(POOL_BLOCKS);
  localparam int FREE_W = $clog2(POOL_BLOCKS + 1);
  localparam int SEQ_W  = 6;
  localparam int SID_W  = (MAX_SEQS > 1) ? $clog2(MAX_SEQS) : 1;
  localparam int BI_W   = (MAX_BLOCKS_PER_SEQ > 1) ? $clog2(MAX_BLOCKS_PER_SEQ) : 1;
  localparam int CNT_W  = 6;
  localparam int TBL_W  = $clog2(MAX_SEQS * MAX_BLOCKS_PER_SEQ);

  typedef enum logic [2:0] {
    CMD_ALLOC     = 3'd0,
    CMD_APP_TOK   = 3'd1,
    CMD_APP_BLK   = 3'd2,
    CMD_RELEASE   = 3'd3,
    CMD_CAN_ALLOC = 3'd4,
    CMD_TRANSLATE = 3'd5,
    CMD_QUERY     = 3'd6,
    CMD_BAD       = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_MISSING = 3'd2,
    ST_FEW     = 3'd3,
    ST_BADARG  = 3'd4,
    ST_FULL    = 3'd5,
    ST_BEYOND  = 3'd6
  } status_t;

  localparam logic REG_BLOCK_SIZE = 1'b0;
  localparam logic REG_RESERVED   = 1'b1;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DIV,
    S_DECIDE,
    S_ADD,
    S_ADD_WR,
    S_REL_RD,
    S_REL_WR,
    S_TR_RD,
    S_TR_MUL,
    S_OUT
  } state_t;

  // divider request and answer
  typedef struct packed {
    logic        start;
    logic [16:0] dividend;
    logic [8:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quot;
    logic [8:0]  rem;
  } div_rsp_t;

endpackage

/* rtl/pcba_div.sv */
// ----------------------------------------------------------------------------
// pcba_div
// restoring divider, one quotient bit per cycle, 17-bit by 9-bit
// ----------------------------------------------------------------------------
module pcba_div import pcba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [16:0] quot;
  logic [9:0]  rem;
  logic [8:0]  dsr;
  logic [4:0]  bits;
  logic        busy;
  logic        done;
  logic [9:0]  trial;

  always_comb begin
    trial = {rem[8:0], quot[16]} - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quot <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
        bits <= 5'd17;
      end else if (busy) begin
        if ({rem[8:0], quot[16]} >= {1'b0, dsr}) begin
          rem  <= trial;
          quot <= {quot[15:0], 1'b1};
        end else begin
          rem  <= {rem[8:0], quot[16]};
          quot <= {quot[15:0], 1'b0};
        end
        bits <= bits - 5'd1;
        if (bits == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem[8:0];

endmodule

/* rtl/paged_cache_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// paged_cache_block_allocator_top
// free list and per-sequence block table with a command sequencer
// ----------------------------------------------------------------------------
// After reset the block fills the free list with ids in order, and clears
// the sequence table in the same pass. It accepts no command during that
// time. A command is taken only while the sequencer is idle. Every command
// first runs the shared serial divider on its length. Append tokens runs it
// a second time, on the tokens left after the room in the last block. Each
// added block passes through a free list read and a table write, and each
// released block through a table read and a free list write, over the single
// table memory port. The output register holds the last word, so the next
// command can run its divide while that word waits. Its decide step waits
// until the word has been taken.
module paged_cache_block_allocator_top import pcba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[2:0], seq_id[8:3], length[24:9], token_count[40:25], zero fill
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], block_id[12:3], slot[30:13], flag[31], block_count[37:32],
  // free_count[48:38], zero fill
  output logic [55:0] m_tdata,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata
);

  state_t state, state_next;

  logic [8:0]  blk_tokens;
  logic [10:0] keep_free;
  logic [8:0]  bs;

  logic [BLK_W-1:0] free_queue [POOL_BLOCKS];
  logic [BLK_W-1:0] block_table [MAX_SEQS * MAX_BLOCKS_PER_SEQ];
  logic [BLK_W-1:0] fq_rd, bt_rd;
  logic [BLK_W-1:0] free_head, free_tail;
  logic [FREE_W-1:0] free_total;
  logic [BLK_W:0]    init_cnt;
  logic              seq_valid [MAX_SEQS];
  logic [CNT_W-1:0]  seq_blocks [MAX_SEQS];

  // latched command
  cmd_t         cmd;
  logic [5:0]   sid;
  logic [15:0]  len;
  logic [15:0]  tok;
  logic         valid;
  logic [CNT_W-1:0] cnt;
  logic         div_phase;
  logic [16:0]  q1;
  logic [8:0]   r1;
  logic [16:0]  need;
  logic [CNT_W-1:0] idx;

  // output register
  logic [2:0]  o_status;
  logic [9:0]  o_blk;
  logic [17:0] o_slot;
  logic        o_flag;
  logic [5:0]  o_cnt;
  logic        o_last;
  logic        o_full;
  logic [FREE_W-1:0] free_total_out;

  div_req_t dreq;
  div_rsp_t drsp;

  pcba_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign bs = (blk_tokens == 9'd0) ? 9'd1 : ((blk_tokens > 9'd256) ? 9'd256 : blk_tokens);
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = o_full;
  assign m_tlast  = o_last;
  assign m_tdata  = {7'd0, free_total_out, o_cnt, o_flag, o_slot, o_blk, o_status};

  always_ff @(posedge clk) begin
    if (state == S_OUT) free_total_out <= free_total;
    else if (state == S_ADD_WR) free_total_out <= free_total - 1'b1;
  end

  // ceil helpers from divider results
  logic [16:0] ceil_len;
  assign ceil_len = q1 + 17'd1;

  logic [8:0] room;
  assign room = (r1 == 9'd0) ? 9'd0 : (bs - r1);

  logic [17:0] prod;
  logic        ok_fit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      blk_tokens <= 9'd16;
      keep_free  <= 11'd0;
      free_head  <= '0;
      free_tail  <= '0;
      free_total <= FREE_W'(POOL_BLOCKS);
      init_cnt   <= '0;
      o_full     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == REG_BLOCK_SIZE) blk_tokens <= cfg_wdata[8:0];
        else keep_free <= cfg_wdata;
      end
      if (o_full && m_tready) o_full <= 1'b0;
      unique case (state)
        S_INIT: begin
          free_queue[init_cnt[BLK_W-1:0]] <= init_cnt[BLK_W-1:0];
          seq_valid[init_cnt[SID_W-1:0]]  <= 1'b0;
          seq_blocks[init_cnt[SID_W-1:0]] <= '0;
          init_cnt <= init_cnt + 1'b1;
        end
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            cmd       <= cmd_t'(s_tdata[2:0]);
            sid       <= s_tdata[8:3];
            len       <= s_tdata[24:9];
            tok       <= s_tdata[40:25];
            valid     <= seq_valid[s_tdata[3 +: SID_W]];
            cnt       <= seq_valid[s_tdata[3 +: SID_W]] ? seq_blocks[s_tdata[3 +: SID_W]] : '0;
            div_phase <= 1'b0;
            idx       <= '0;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            if (!div_phase) begin
              q1 <= drsp.quot;
              r1 <= drsp.rem;
              div_phase <= (cmd == CMD_APP_TOK);
            end else begin
              need <= drsp.quot + 17'd1;
              div_phase <= 1'b0;
            end
          end
        end
        S_DECIDE: begin
          if (!o_full) begin
            o_status <= ST_OK; o_blk <= '0; o_slot <= '0; o_flag <= 1'b0;
            o_cnt <= cnt; o_last <= 1'b1;
            if (cmd == CMD_ALLOC || cmd == CMD_CAN_ALLOC) need <= ceil_len;
            priority if (cmd == CMD_CAN_ALLOC) begin
              o_cnt <= '0;
              if (len == 16'd0) o_status <= ST_BADARG;
              else if (ceil_len > 17'(MAX_BLOCKS_PER_SEQ)) o_status <= ST_FULL;
              else o_flag <= ({1'b0, free_total} >= 12'(ceil_len) + {1'b0, keep_free});
            end else if (cmd == CMD_BAD) begin
              o_status <= ST_BADARG; o_cnt <= '0;
            end else if (cmd == CMD_ALLOC) begin
              if (valid) o_status <= ST_EXISTS;
              else begin
                o_cnt <= '0;
                if (len == 16'd0) o_status <= ST_BADARG;
                else if (ceil_len > 17'(MAX_BLOCKS_PER_SEQ)) o_status <= ST_FULL;
                else if ({1'b0, free_total} < 12'(ceil_len) + {1'b0, keep_free})
                  o_status <= ST_FEW;
              end
            end else if (cmd == CMD_APP_TOK) begin
              if (tok == 16'd0) o_status <= ST_BADARG;
              else if (!valid) begin o_status <= ST_MISSING; end
              else if (len == 16'd0) o_status <= ST_BADARG;
              else if (tok > {7'd0, room}) begin
                if (17'(cnt) + need > 17'(MAX_BLOCKS_PER_SEQ)) o_status <= ST_FULL;
                else if (17'(free_total) <= need) o_status <= ST_FEW;
              end
            end else if (cmd == CMD_APP_BLK) begin
              need <= 17'd1;
              if (free_total == '0) o_status <= ST_FEW;
              else if (!valid) o_status <= ST_MISSING;
              else if (cnt >= CNT_W'(MAX_BLOCKS_PER_SEQ)) o_status <= ST_FULL;
            end else if (cmd == CMD_RELEASE) begin
              o_cnt <= '0;
              if (!valid) o_status <= ST_MISSING;
            end else if (cmd == CMD_TRANSLATE) begin
              if (!valid) o_status <= ST_MISSING;
              else if (q1 >= 17'(cnt) || q1 >= 17'(MAX_BLOCKS_PER_SEQ)) o_status <= ST_BEYOND;
            end else begin
              o_flag <= valid;
            end
            if (ok_fit && cmd == CMD_ALLOC) begin
              seq_valid[sid[SID_W-1:0]] <= 1'b1;
              cnt <= '0;
            end
          end
        end
        S_ADD: begin
          fq_rd <= free_queue[free_head];
        end
        S_ADD_WR: begin
          block_table[{sid[SID_W-1:0], cnt[BI_W-1:0]}] <= fq_rd;
          free_head  <= free_head + 1'b1;
          free_total <= free_total - 1'b1;
          cnt        <= cnt + 1'b1;
          seq_blocks[sid[SID_W-1:0]] <= cnt + 1'b1;
          need       <= need - 17'd1;
          o_status <= ST_OK; o_blk <= fq_rd; o_slot <= '0; o_flag <= 1'b0;
          o_cnt <= cnt + 1'b1; o_last <= (need == 17'd1);
          o_full <= 1'b1;
        end
        S_REL_RD: begin
          bt_rd <= block_table[{sid[SID_W-1:0], idx[BI_W-1:0]}];
        end
        S_REL_WR: begin
          free_queue[free_tail] <= bt_rd;
          free_tail  <= free_tail + 1'b1;
          free_total <= free_total + 1'b1;
          idx        <= idx + 1'b1;
        end
        S_TR_RD: begin
          bt_rd <= block_table[{sid[SID_W-1:0], q1[BI_W-1:0]}];
        end
        S_TR_MUL: begin
          prod <= 18'({8'd0, bt_rd} * {9'd0, bs});
        end
        S_OUT: begin
          if (cmd == CMD_TRANSLATE && o_status == ST_OK) begin
            o_blk  <= bt_rd;
            o_slot <= prod + 18'(r1);
          end
          if (cmd == CMD_RELEASE && o_status == ST_OK) begin
            seq_valid[sid[SID_W-1:0]]  <= 1'b0;
            seq_blocks[sid[SID_W-1:0]] <= '0;
          end
          o_full <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // success path of the decide step
  always_comb begin
    ok_fit = 1'b0;
    if (cmd == CMD_ALLOC)
      ok_fit = !valid && len != 16'd0 && ceil_len <= 17'(MAX_BLOCKS_PER_SEQ) &&
               {1'b0, free_total} >= 12'(ceil_len) + {1'b0, keep_free};
    else if (cmd == CMD_APP_TOK)
      ok_fit = tok != 16'd0 && valid && len != 16'd0 && tok > {7'd0, room} &&
               17'(cnt) + need <= 17'(MAX_BLOCKS_PER_SEQ) && 17'(free_total) > need;
    else if (cmd == CMD_APP_BLK)
      ok_fit = free_total != '0 && valid && cnt < CNT_W'(MAX_BLOCKS_PER_SEQ);
  end

  always_comb begin
    state_next = state;
    dreq.start    = 1'b0;
    dreq.dividend = {1'b0, len - 16'd1};
    dreq.divisor  = bs;
    unique case (state)
      S_INIT: if (init_cnt == (BLK_W+1)'(POOL_BLOCKS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          state_next = S_DIV;
          dreq.start = 1'b1;
          if (cmd_t'(s_tdata[2:0]) == CMD_TRANSLATE || cmd_t'(s_tdata[2:0]) == CMD_APP_TOK)
            dreq.dividend = {1'b0, s_tdata[24:9]};
          else
            dreq.dividend = {1'b0, s_tdata[24:9] - 16'd1};
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          if (!div_phase && cmd == CMD_APP_TOK) begin
            dreq.start = 1'b1;
            dreq.dividend = {1'b0, tok - 16'd1 -
              ((drsp.rem == 9'd0) ? 16'd0 : 16'(bs - drsp.rem))};
          end else state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!o_full) begin
          if (ok_fit) state_next = S_ADD;
          else if (cmd == CMD_RELEASE && valid && cnt != '0) state_next = S_REL_RD;
          else if (cmd == CMD_TRANSLATE && valid && q1 < 17'(cnt) &&
                   q1 < 17'(MAX_BLOCKS_PER_SEQ)) state_next = S_TR_RD;
          else state_next = S_OUT;
        end
      end
      S_ADD:    if (!o_full) state_next = S_ADD_WR;
      S_ADD_WR: state_next = (need == 17'd1) ? S_IDLE : S_ADD;
      S_REL_RD: state_next = S_REL_WR;
      S_REL_WR: state_next = (idx + 1'b1 == cnt) ? S_OUT : S_REL_RD;
      S_TR_RD:  state_next = S_TR_MUL;
      S_TR_MUL: state_next = S_OUT;
      S_OUT:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // free list accounting never exceeds the pool
  assert property (@(posedge clk) disable iff (rst)
    free_total <= FREE_W'(POOL_BLOCKS)) else $error("free count beyond pool");

  // no command taken while the previous command is in progress
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("command overlap");

  // a pop only happens with free blocks present
  assert property (@(posedge clk) disable iff (rst)
    state == S_ADD_WR |-> free_total != '0) else $error("pop from empty free list");

endmodule

/* tb/pcba_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcba_checker
// watches the command, result and register channels of the block allocator,
// keeps its own copy of the free list and sequence table, predicts every
// result word of each accepted command and compares the result words in order
// ----------------------------------------------------------------------------
module pcba_checker import pcba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [55:0] data;
    logic        last;
  } result_word_t;

  result_word_t    expected_words[$];

  logic [8:0]      blk_tokens;
  logic [10:0]     keep_free;
  logic [BLK_W-1:0] free_ring [POOL_BLOCKS];
  int              ring_head;
  int              ring_tail;
  int              free_total;
  logic            seq_live [MAX_SEQS];
  int              seq_nblk [MAX_SEQS];
  logic [BLK_W-1:0] blk_map [MAX_SEQS*MAX_BLOCKS_PER_SEQ];

  assign pending = expected_words.size();

  task automatic clear_state();
    blk_tokens = 9'd16;
    keep_free  = 11'd0;
    for (int i = 0; i < POOL_BLOCKS; i++) free_ring[i] = BLK_W'(i);
    ring_head  = 0;
    ring_tail  = 0;
    free_total = POOL_BLOCKS;
    for (int i = 0; i < MAX_SEQS; i++) begin
      seq_live[i] = 1'b0;
      seq_nblk[i] = 0;
    end
    expected_words.delete();
  endtask

  function automatic int eff_blk_tokens();
    if (blk_tokens == 0) return 1;
    if (blk_tokens > 256) return 256;
    return int'(blk_tokens);
  endfunction

  task automatic push_word(status_t st, int blk, int slot, bit flag, int cnt, bit last);
    result_word_t w;
    w.data = {7'd0, 11'(free_total), 6'(cnt), flag, 18'(slot), 10'(blk), 3'(st)};
    w.last = last;
    expected_words.push_back(w);
  endtask

  task automatic grant_blocks(int sid, int n);
    int b;
    for (int i = 0; i < n; i++) begin
      b = free_ring[ring_head];
      ring_head = (ring_head + 1) % POOL_BLOCKS;
      free_total--;
      blk_map[sid*MAX_BLOCKS_PER_SEQ + seq_nblk[sid]] = BLK_W'(b);
      seq_nblk[sid]++;
      push_word(ST_OK, b, 0, 1'b0, seq_nblk[sid], i == n - 1);
    end
  endtask

  task automatic predict_command(cmd_t c, int sid, int len, int tok);
    int bs, cnt, need, room, add, bi, b;
    bit live;
    bs   = eff_blk_tokens();
    live = seq_live[sid];
    cnt  = live ? seq_nblk[sid] : 0;
    case (c)
      CMD_CAN_ALLOC: begin
        if (len == 0) push_word(ST_BADARG, 0, 0, 1'b0, 0, 1'b1);
        else begin
          need = (len - 1) / bs + 1;
          if (need > MAX_BLOCKS_PER_SEQ) push_word(ST_FULL, 0, 0, 1'b0, 0, 1'b1);
          else push_word(ST_OK, 0, 0, free_total >= need + keep_free, 0, 1'b1);
        end
      end
      CMD_ALLOC: begin
        need = (len == 0) ? 0 : (len - 1) / bs + 1;
        if (live) push_word(ST_EXISTS, 0, 0, 1'b0, cnt, 1'b1);
        else if (len == 0) push_word(ST_BADARG, 0, 0, 1'b0, 0, 1'b1);
        else if (need > MAX_BLOCKS_PER_SEQ) push_word(ST_FULL, 0, 0, 1'b0, 0, 1'b1);
        else if (free_total < need + keep_free) push_word(ST_FEW, 0, 0, 1'b0, 0, 1'b1);
        else begin
          seq_live[sid] = 1'b1;
          seq_nblk[sid] = 0;
          grant_blocks(sid, need);
        end
      end
      CMD_APP_TOK: begin
        if (tok == 0) push_word(ST_BADARG, 0, 0, 1'b0, cnt, 1'b1);
        else if (!live) push_word(ST_MISSING, 0, 0, 1'b0, 0, 1'b1);
        else if (len == 0) push_word(ST_BADARG, 0, 0, 1'b0, cnt, 1'b1);
        else begin
          room = (bs - len % bs) % bs;
          if (tok <= room) push_word(ST_OK, 0, 0, 1'b0, cnt, 1'b1);
          else begin
            add = (tok - room - 1) / bs + 1;
            if (cnt + add > MAX_BLOCKS_PER_SEQ) push_word(ST_FULL, 0, 0, 1'b0, cnt, 1'b1);
            else if (free_total <= add) push_word(ST_FEW, 0, 0, 1'b0, cnt, 1'b1);
            else grant_blocks(sid, add);
          end
        end
      end
      CMD_APP_BLK: begin
        if (free_total == 0) push_word(ST_FEW, 0, 0, 1'b0, cnt, 1'b1);
        else if (!live) push_word(ST_MISSING, 0, 0, 1'b0, 0, 1'b1);
        else if (cnt >= MAX_BLOCKS_PER_SEQ) push_word(ST_FULL, 0, 0, 1'b0, cnt, 1'b1);
        else grant_blocks(sid, 1);
      end
      CMD_RELEASE: begin
        if (!live) push_word(ST_MISSING, 0, 0, 1'b0, 0, 1'b1);
        else begin
          for (int i = 0; i < cnt; i++) begin
            free_ring[ring_tail] = blk_map[sid*MAX_BLOCKS_PER_SEQ + i];
            ring_tail = (ring_tail + 1) % POOL_BLOCKS;
            free_total++;
          end
          seq_live[sid] = 1'b0;
          seq_nblk[sid] = 0;
          push_word(ST_OK, 0, 0, 1'b0, 0, 1'b1);
        end
      end
      CMD_TRANSLATE: begin
        if (!live) push_word(ST_MISSING, 0, 0, 1'b0, 0, 1'b1);
        else begin
          bi = len / bs;
          if (bi >= cnt) push_word(ST_BEYOND, 0, 0, 1'b0, cnt, 1'b1);
          else begin
            b = blk_map[sid*MAX_BLOCKS_PER_SEQ + bi];
            push_word(ST_OK, b, b * bs + len % bs, 1'b0, cnt, 1'b1);
          end
        end
      end
      CMD_QUERY: push_word(ST_OK, 0, 0, live, cnt, 1'b1);
      default:   push_word(ST_BADARG, 0, 0, 1'b0, 0, 1'b1);
    endcase
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    result_word_t w;
    if (rst) begin
      errors = 0;
      clear_state();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual %h last %b",
                   $time, m_tdata, m_tlast);
        end else begin
          w = expected_words.pop_front();
          check_field("status", w.data[2:0], m_tdata[2:0]);
          check_field("blk_id", w.data[12:3], m_tdata[12:3]);
          check_field("slot", w.data[30:13], m_tdata[30:13]);
          check_field("flag", w.data[31], m_tdata[31]);
          check_field("block_count", w.data[37:32], m_tdata[37:32]);
          check_field("free_count", w.data[48:38], m_tdata[48:38]);
          check_field("zero fill", w.data[55:49], m_tdata[55:49]);
          check_field("last", w.last, m_tlast);
        end
      end
      if (s_tvalid && s_tready)
        predict_command(cmd_t'(s_tdata[2:0]), int'(s_tdata[8:3]),
                        int'(s_tdata[24:9]), int'(s_tdata[40:25]));
      if (cfg_we) begin
        if (cfg_index == REG_BLOCK_SIZE) blk_tokens = cfg_wdata[8:0];
        else keep_free = cfg_wdata;
      end
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the paged cache block allocator: directed corner commands,
// a pool exhaustion sequence, then random command mixes over several block
// sizes and reserve settings with random idling on both stream sides
// ----------------------------------------------------------------------------
module tb;
  import pcba_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_BLOCK_SIZE;
  logic [10:0] cfg_wdata = '0;

  int errors;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_tok = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int cur_bs = 16;

  paged_cache_block_allocator_top dut (.*);

  pcba_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_tok != hold_seen) begin
      hold_seen <= hold_tok;
      hold_left <= 400;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_cmd(cmd_t c, int sid, int len, int tok);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, 16'(tok), 16'(len), 6'(sid), 3'(c)};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(logic idx, int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 11'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_blk_tokens(int v);
    write_reg(REG_BLOCK_SIZE, v);
    cur_bs = (v == 0) ? 1 : (v > 256) ? 256 : v;
  endtask

  function automatic int pick_len(int hi);
    if ($urandom_range(0, 99) < 12) return $urandom & 16'hFFFF;
    return $urandom_range(0, (hi > 65535) ? 65535 : hi);
  endfunction

  task automatic send_random();
    int r, sid;
    cmd_t c;
    r = $urandom_range(0, 99);
    c = (r < 25) ? CMD_ALLOC : (r < 45) ? CMD_APP_TOK : (r < 55) ? CMD_APP_BLK :
        (r < 70) ? CMD_RELEASE : (r < 78) ? CMD_CAN_ALLOC : (r < 90) ? CMD_TRANSLATE :
        (r < 97) ? CMD_QUERY : CMD_BAD;
    sid = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 15) : $urandom_range(0, 63);
    send_cmd(c, sid, pick_len(cur_bs * 34), pick_len(cur_bs * 4));
  endtask

  task automatic random_phase(int n, int idle_pct, int stall_pct, bit with_hold);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == 20) hold_tok <= hold_tok + 1;
      send_random();
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_blk_tokens(16);
    write_reg(REG_RESERVED, 0);

    send_cmd(CMD_ALLOC, 0, 1, 0);
    send_cmd(CMD_ALLOC, 0, 1, 0);
    send_cmd(CMD_ALLOC, 1, 0, 0);
    send_cmd(CMD_ALLOC, 2, 65535, 65535);
    send_cmd(CMD_ALLOC, 63, 512, 0);
    send_cmd(CMD_APP_TOK, 3, 1, 0);
    send_cmd(CMD_APP_TOK, 3, 1, 5);
    send_cmd(CMD_APP_TOK, 0, 0, 5);
    send_cmd(CMD_APP_TOK, 0, 1, 15);
    send_cmd(CMD_APP_TOK, 0, 1, 40);
    send_cmd(CMD_APP_TOK, 63, 512, 65535);
    send_cmd(CMD_APP_BLK, 0, 0, 0);
    send_cmd(CMD_APP_BLK, 5, 0, 0);
    send_cmd(CMD_APP_BLK, 63, 0, 0);
    send_cmd(CMD_CAN_ALLOC, 0, 0, 0);
    send_cmd(CMD_CAN_ALLOC, 0, 65535, 0);
    send_cmd(CMD_CAN_ALLOC, 0, 100, 0);
    send_cmd(CMD_TRANSLATE, 7, 0, 0);
    send_cmd(CMD_TRANSLATE, 0, 65535, 0);
    send_cmd(CMD_TRANSLATE, 0, 17, 0);
    send_cmd(CMD_QUERY, 0, 0, 0);
    send_cmd(CMD_QUERY, 9, 0, 0);
    send_cmd(CMD_RELEASE, 9, 0, 0);
    send_cmd(CMD_RELEASE, 63, 0, 0);
    send_cmd(CMD_BAD, 42, 65535, 65535);
    drain();

    write_reg(REG_RESERVED, 2047);
    send_cmd(CMD_CAN_ALLOC, 4, 1, 0);
    send_cmd(CMD_ALLOC, 4, 1, 0);
    drain();
    write_reg(REG_RESERVED, 0);

    // exhaust the pool, then hit the empty free list
    for (int s = 16; s < 56; s++) send_cmd(CMD_ALLOC, s, 512, 0);
    send_cmd(CMD_ALLOC, 56, 448, 0);
    send_cmd(CMD_APP_BLK, 56, 0, 0);
    send_cmd(CMD_APP_TOK, 56, 448, 1);
    send_cmd(CMD_CAN_ALLOC, 0, 1, 0);
    for (int s = 16; s < 57; s++) send_cmd(CMD_RELEASE, s, 0, 0);
    drain();

    set_blk_tokens(1);
    random_phase(67, 0, 0, 1'b1);
    set_blk_tokens(511);
    write_reg(REG_RESERVED, 1000);
    random_phase(67, 49, 0, 1'b0);
    set_blk_tokens(0);
    write_reg(REG_RESERVED, 3);
    random_phase(67, 0, 49, 1'b0);
    set_blk_tokens($urandom_range(1, 256));
    write_reg(REG_RESERVED, $urandom_range(0, 1024));
    random_phase(67, 10, 10, 1'b0);

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pcba_pkg.sv
rtl/pcba_div.sv
rtl/paged_cache_block_allocator_top.sv
tb/pcba_checker.sv
tb/tb.sv
